// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
// ASSERT_IMPL checks a same-cycle implication and ASSERT_NEXT checks a
// next-cycle implication. Both are disabled while the reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: design/skse_pkg.sv
`timescale 1ns / 1ps
package skse_pkg;

  localparam int unsigned KeyW = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DUMP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_ITEM     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOCATE,
    S_INS_SHIFT,
    S_DEL_SHIFT,
    S_DUMP
  } state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_INC,
    IDX_DEC,
    IDX_LOAD_CNT
  } idx_op_e;

  // Offset of the prefetched entry relative to the next index value.
  typedef enum logic [1:0] {
    RD_SAME,
    RD_BELOW,
    RD_ABOVE
  } rd_off_e;

  typedef enum logic {
    WR_RDATA,
    WR_KEY
  } wr_src_e;

  typedef enum logic [1:0] {
    KEY_ZERO,
    KEY_OPERAND,
    KEY_RDATA
  } key_src_e;

  typedef struct packed {
    idx_op_e  idx_op;
    rd_off_e  rd_off;
    logic     key_load;
    logic     pos_load;
    logic     wr_en;
    wr_src_e  wr_src;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     out_load;
    status_e  out_status;
    key_src_e out_key_src;
    logic     out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic at_end;
    logic at_pos;
    logic last_item;
    logic key_eq;
    logic key_gt;
    logic out_free;
  } dp_status_t;

endpackage

// File: design/skse_if.sv
`timescale 1ns / 1ps
interface skse_in_if;
  import skse_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic signed [KeyW-1:0] key_in;

  modport source (output valid, output opcode, output key_in, input ready);
  modport sink   (input valid, input opcode, input key_in, output ready);
endinterface

interface skse_out_if;
  import skse_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [2:0]             status;
  logic signed [KeyW-1:0] key_out;
  logic                   last;

  modport source (output valid, output status, output key_out, output last, input ready);
  modport sink   (input valid, input status, input key_out, input last, output ready);
endinterface

// File: design/sorted_key_set_engine.sv
// Sorted key set: holds up to CAPACITY distinct signed 32-bit keys in
// ascending order in a single-port-read, single-port-write RAM.
// Input channel in_i carries an opcode (insert, delete, search, dump) and a
// key; output channel out_o carries status, key_out and last. Both use a
// valid/ready transfer. Every operation ends with exactly one result that
// has last set; a dump gives one result per stored key, or one empty status.
// With p the sorted position of the key, a search scans the entries from
// 0 up to p; an insert scans likewise, then moves each stored entry from
// p upward up one slot; a delete scans, then moves each entry above p down
// one slot; a dump gives one key per cycle while the receiver takes them.
// The RAM reads one entry and writes one per cycle, so both the ordered
// search and the shift walk one entry a cycle.
// A new item is taken only when the engine is idle, in the cycle after the
// previous result is loaded, so the slowest items are inserts and deletes
// near a full set. The result register lets it take the next item while
// the last result still waits. When the receiver stalls, the engine holds
// its position and resumes once the result register drains. Reset empties
// the set at once; the RAM contents are not cleared and are never read
// above the key count.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sorted_key_set_engine #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  skse_in_if.sink    in_i,
  skse_out_if.source out_o
);
  import skse_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t dp_st;
  logic       in_ready;
  status_e    out_status;

  skse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .opcode_i   (in_i.opcode),
    .in_ready_o (in_ready),
    .st_i       (dp_st),
    .cmd_o      (cmd)
  );

  skse_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (dp_st),
    .key_i        (in_i.key_in),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_status),
    .out_key_o    (out_o.key_out),
    .out_last_o   (out_o.last)
  );

  assign in_i.ready   = in_ready;
  assign out_o.status = out_status;

  // A result is never loaded over one that has not been transferred.
  `ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd.out_load, dp_st.out_free)
  // The count never grows past the capacity.
  `ASSERT_IMPL(a_no_overfill, clk_i, rst_ni, cmd.cnt_inc, !dp_st.cnt_full)
  // The count changes only together with the final result of an item.
  `ASSERT_IMPL(a_cnt_with_result, clk_i, rst_ni, cmd.cnt_inc || cmd.cnt_dec, cmd.out_load)
  // Once an item is taken, the engine is busy in the next cycle.
  `ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_i.valid && in_ready, !in_ready)

endmodule

// File: design/skse_ctrl.sv
`timescale 1ns / 1ps
module skse_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           opcode_i,
  output logic                 in_ready_o,
  input  skse_pkg::dp_status_t st_i,
  output skse_pkg::dp_cmd_t    cmd_o
);
  import skse_pkg::*;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   hit;

  assign hit = !st_i.at_end && st_i.key_eq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_INSERT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    op_d               = op_q;
    in_ready_o         = 1'b0;
    cmd_o.idx_op       = IDX_HOLD;
    cmd_o.rd_off       = RD_SAME;
    cmd_o.key_load     = 1'b0;
    cmd_o.pos_load     = 1'b0;
    cmd_o.wr_en        = 1'b0;
    cmd_o.wr_src       = WR_RDATA;
    cmd_o.cnt_inc      = 1'b0;
    cmd_o.cnt_dec      = 1'b0;
    cmd_o.out_load     = 1'b0;
    cmd_o.out_status   = ST_DONE;
    cmd_o.out_key_src  = KEY_ZERO;
    cmd_o.out_last     = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        // Keep the index at zero so entry 0 is prefetched on the transfer.
        cmd_o.idx_op = IDX_CLR;
        if (in_valid_i) begin
          cmd_o.key_load = 1'b1;
          op_d           = op_e'(opcode_i);
          state_d        = (op_e'(opcode_i) == OP_DUMP) ? S_DUMP : S_LOCATE;
        end
      end

      S_LOCATE: begin
        if (!st_i.at_end && !st_i.key_eq && !st_i.key_gt) begin
          cmd_o.idx_op = IDX_INC;
        end else begin
          unique case (op_q)
            OP_INSERT: begin
              priority if (hit) begin
                if (st_i.out_free) begin
                  cmd_o.out_load   = 1'b1;
                  cmd_o.out_status = ST_DUP;
                  state_d          = S_IDLE;
                end
              end else if (st_i.cnt_full) begin
                if (st_i.out_free) begin
                  cmd_o.out_load   = 1'b1;
                  cmd_o.out_status = ST_FULL;
                  state_d          = S_IDLE;
                end
              end else begin
                cmd_o.pos_load = 1'b1;
                cmd_o.idx_op   = IDX_LOAD_CNT;
                cmd_o.rd_off   = RD_BELOW;
                state_d        = S_INS_SHIFT;
              end
            end
            OP_DELETE: begin
              if (hit) begin
                cmd_o.rd_off = RD_ABOVE;
                state_d      = S_DEL_SHIFT;
              end else if (st_i.out_free) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_NOTFOUND;
                state_d          = S_IDLE;
              end
            end
            OP_SEARCH: begin
              if (st_i.out_free) begin
                cmd_o.out_load = 1'b1;
                state_d        = S_IDLE;
                priority if (st_i.cnt_zero) begin
                  cmd_o.out_status = ST_EMPTY;
                end else if (hit) begin
                  cmd_o.out_status  = ST_DONE;
                  cmd_o.out_key_src = KEY_OPERAND;
                end else begin
                  cmd_o.out_status = ST_NOTFOUND;
                end
              end
            end
            OP_DUMP: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_INS_SHIFT: begin
        // Walk down from the count, moving each entry up by one slot.
        cmd_o.rd_off = RD_BELOW;
        if (st_i.at_pos) begin
          if (st_i.out_free) begin
            cmd_o.wr_en    = 1'b1;
            cmd_o.wr_src   = WR_KEY;
            cmd_o.cnt_inc  = 1'b1;
            cmd_o.out_load = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.idx_op = IDX_DEC;
        end
      end

      S_DEL_SHIFT: begin
        cmd_o.rd_off = RD_ABOVE;
        if (st_i.last_item) begin
          if (st_i.out_free) begin
            cmd_o.cnt_dec  = 1'b1;
            cmd_o.out_load = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.idx_op = IDX_INC;
        end
      end

      S_DUMP: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (st_i.cnt_zero) begin
            cmd_o.out_status = ST_EMPTY;
            state_d          = S_IDLE;
          end else begin
            cmd_o.out_status  = ST_ITEM;
            cmd_o.out_key_src = KEY_RDATA;
            cmd_o.out_last    = st_i.last_item;
            cmd_o.idx_op      = IDX_INC;
            if (st_i.last_item) begin
              state_d = S_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/skse_dp.sv
`timescale 1ns / 1ps
module skse_dp #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  skse_pkg::dp_cmd_t                cmd_i,
  output skse_pkg::dp_status_t             st_o,
  input  logic signed [skse_pkg::KeyW-1:0] key_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output skse_pkg::status_e                out_status_o,
  output logic signed [skse_pkg::KeyW-1:0] out_key_o,
  output logic                             out_last_o
);
  import skse_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] CapVal = IW'(CAPACITY);

  logic signed [KeyW-1:0] mem_q [CAPACITY];
  logic signed [KeyW-1:0] rdata_q, key_q, wdata, out_key_q;
  logic [IW-1:0]          idx_q, idx_d, cnt_q, cnt_d, pos_q, rd_idx;
  logic [AW-1:0]          rd_addr;
  logic                   out_valid_q;
  status_e                out_status_q;
  logic                   out_last_q;
  logic                   out_free;

  always_comb begin
    unique case (cmd_i.idx_op)
      IDX_HOLD:     idx_d = idx_q;
      IDX_CLR:      idx_d = '0;
      IDX_INC:      idx_d = idx_q + IW'(1);
      IDX_DEC:      idx_d = idx_q - IW'(1);
      IDX_LOAD_CNT: idx_d = cnt_q;
      default:      idx_d = idx_q;
    endcase
  end

  // The RAM is addressed with the next index so that its registered output
  // holds the entry the controller looks at in the following cycle.
  always_comb begin
    unique case (cmd_i.rd_off)
      RD_SAME:  rd_idx = idx_d;
      RD_BELOW: rd_idx = idx_d - IW'(1);
      RD_ABOVE: rd_idx = idx_d + IW'(1);
      default:  rd_idx = idx_d;
    endcase
  end

  assign rd_addr = rd_idx[AW-1:0];
  assign wdata   = (cmd_i.wr_src == WR_KEY) ? key_q : rdata_q;
  assign cnt_d   = cnt_q + IW'(cmd_i.cnt_inc) - IW'(cmd_i.cnt_dec);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[idx_q[AW-1:0]] <= wdata;
    end
    if (rd_idx < CapVal) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_load) begin
      key_q <= key_i;
    end
    if (cmd_i.pos_load) begin
      pos_q <= idx_q;
    end
  end

  // Output register: a result waits here while the next item is taken in.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_last_q   <= cmd_i.out_last;
      unique case (cmd_i.out_key_src)
        KEY_ZERO:    out_key_q <= '0;
        KEY_OPERAND: out_key_q <= key_q;
        KEY_RDATA:   out_key_q <= rdata_q;
        default:     out_key_q <= '0;
      endcase
    end
  end

  assign st_o.cnt_zero  = (cnt_q == '0);
  assign st_o.cnt_full  = (cnt_q == CapVal);
  assign st_o.at_end    = (idx_q == cnt_q);
  assign st_o.at_pos    = (idx_q == pos_q);
  assign st_o.last_item = ((idx_q + IW'(1)) == cnt_q);
  assign st_o.key_eq    = (rdata_q == key_q);
  assign st_o.key_gt    = (rdata_q > key_q);
  assign st_o.out_free  = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_key_o    = out_key_q;
  assign out_last_o   = out_last_q;

endmodule

// File: test/sorted_key_set_engine_test.sv
`timescale 1ns / 1ps
module sorted_key_set_engine_test;
  import skse_pkg::*;

  localparam int CAPACITY = 32;
  localparam logic signed [KeyW-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KeyW-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic signed [KeyW-1:0] KEY_NONE = '0;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    status_e                status;
    logic signed [KeyW-1:0] key;
    logic                   last;
  } result_t;

  typedef struct {
    op_e                    op;
    logic signed [KeyW-1:0] key;
    bit                     typed;
    status_e                status;
    logic signed [KeyW-1:0] key_out;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  skse_in_if  in_bus ();
  skse_out_if out_bus ();

  sorted_key_set_engine #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the ordered key set.
  logic signed [KeyW-1:0] set_keys [CAPACITY];
  int                     set_count;
  int                     peak_count;

  result_t   op_results[$];
  result_t   expected_results[$];
  stim_row_t directed_plan[$];

  int  fail_count;
  int  results_checked;
  int  items_sent;
  int  status_seen [6];
  bit  calm;
  bit  hold_request;

  function automatic void push_result(input status_e st, input logic signed [KeyW-1:0] k,
                                      input logic lst);
    result_t r;
    r.status = st;
    r.key    = k;
    r.last   = lst;
    op_results.push_back(r);
  endfunction

  // Applies one operation to the shadow set and lists the results it gives.
  function automatic void apply_to_set(input op_e op, input logic signed [KeyW-1:0] key);
    int  pos;
    int  i;
    bit  hit;
    op_results.delete();
    pos = 0;
    while (pos < set_count && set_keys[pos] < key) pos++;
    hit = (pos < set_count) && (set_keys[pos] == key);
    case (op)
      OP_INSERT: begin
        if (hit) begin
          push_result(ST_DUP, KEY_NONE, 1'b1);
        end else if (set_count >= CAPACITY) begin
          push_result(ST_FULL, KEY_NONE, 1'b1);
        end else begin
          for (i = set_count; i > pos; i--) set_keys[i] = set_keys[i-1];
          set_keys[pos] = key;
          set_count++;
          if (set_count > peak_count) peak_count = set_count;
          push_result(ST_DONE, KEY_NONE, 1'b1);
        end
      end
      OP_DELETE: begin
        if (!hit) begin
          push_result(ST_NOTFOUND, KEY_NONE, 1'b1);
        end else begin
          for (i = pos; i + 1 < set_count; i++) set_keys[i] = set_keys[i+1];
          set_count--;
          push_result(ST_DONE, KEY_NONE, 1'b1);
        end
      end
      OP_SEARCH: begin
        if (set_count == 0) push_result(ST_EMPTY, KEY_NONE, 1'b1);
        else if (hit) push_result(ST_DONE, key, 1'b1);
        else push_result(ST_NOTFOUND, KEY_NONE, 1'b1);
      end
      default: begin
        if (set_count == 0) begin
          push_result(ST_EMPTY, KEY_NONE, 1'b1);
        end else begin
          for (i = 0; i < set_count; i++) push_result(ST_ITEM, set_keys[i], i == set_count - 1);
        end
      end
    endcase
  endfunction

  // Keys come from the stored set, its neighbors, the extremes, small values
  // and the full range, so that hits, misses and duplicates all come up often.
  function automatic logic signed [KeyW-1:0] pick_key(input int hit_pct);
    int r;
    int idx;
    r = $urandom_range(0, 99);
    idx = (set_count > 0) ? $urandom_range(0, set_count - 1) : 0;
    if (set_count > 0 && r < hit_pct) return set_keys[idx];
    if (r < hit_pct + 10) begin
      if (set_count == 0) return KEY_MAX;
      return $urandom_range(0, 1) ? set_keys[idx] + 1 : set_keys[idx] - 1;
    end
    if (r < hit_pct + 20) begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return KEY_NONE;
        default: return -1;
      endcase
    end
    if (r < hit_pct + 35) return $signed($urandom_range(0, 31)) - 16;
    return $urandom;
  endfunction

  function automatic void add_row(input op_e op, input logic signed [KeyW-1:0] key,
                                  input bit typed, input status_e st,
                                  input logic signed [KeyW-1:0] k);
    stim_row_t row;
    row.op      = op;
    row.key     = key;
    row.typed   = typed;
    row.status  = st;
    row.key_out = k;
    directed_plan.push_back(row);
  endfunction

  // Offers one operation and waits for its transfer. A typed row supplies its
  // own single expected result; the shadow set is updated either way.
  task automatic offer(input op_e op, input logic signed [KeyW-1:0] key, input bit typed,
                       input status_e st, input logic signed [KeyW-1:0] k);
    result_t r;
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid  <= 1'b1;
    in_bus.opcode <= op;
    in_bus.key_in <= key;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    apply_to_set(op, key);
    if (typed) begin
      r.status = st;
      r.key    = k;
      r.last   = 1'b1;
      expected_results.push_back(r);
    end else begin
      foreach (op_results[i]) expected_results.push_back(op_results[i]);
    end
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic random_phase(input int n, input int w_ins, input int w_del, input int w_srch,
                              input int hit_ins, input int hit_other, input int hold_at,
                              input int calm_n);
    int                     j;
    int                     r;
    op_e                    op;
    logic signed [KeyW-1:0] key;
    for (j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < w_ins) op = OP_INSERT;
      else if (r < w_ins + w_del) op = OP_DELETE;
      else if (r < w_ins + w_del + w_srch) op = OP_SEARCH;
      else op = OP_DUMP;
      key = pick_key(op == OP_INSERT ? hit_ins : hit_other);
      calm = (j < calm_n);
      if (j == hold_at) hold_request = 1'b1;
      offer(op, key, 1'b0, ST_DONE, KEY_NONE);
    end
    calm = 1'b0;
  endtask

  // Result side: random stalls, one long hold-off on request, none while calm.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= calm || ($urandom_range(0, 99) >= 12);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (out_bus.status < 3'd6) status_seen[out_bus.status]++;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: status %0d key %0d last %0d",
                   out_bus.status, out_bus.key_out, out_bus.last);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_bus.status !== want.status || out_bus.key_out !== want.key ||
            out_bus.last !== want.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected status %0d key %0d last %0d, got status %0d key %0d last %0d",
                     want.status, want.key, want.last,
                     out_bus.status, out_bus.key_out, out_bus.last);
        end
      end
    end
  end

  initial begin : stimulus
    int directed_n;
    in_bus.valid  = 1'b0;
    in_bus.opcode = OP_INSERT;
    in_bus.key_in = '0;
    calm          = 1'b0;
    hold_request  = 1'b0;
    set_count     = 0;
    peak_count    = 0;
    fail_count    = 0;
    results_checked = 0;
    items_sent    = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // Empty store first, then extremes, duplicates and middle positions.
    add_row(OP_SEARCH, KEY_NONE, 1, ST_EMPTY,    KEY_NONE);
    add_row(OP_DUMP,   KEY_MAX,  1, ST_EMPTY,    KEY_NONE);
    add_row(OP_DELETE, 5,        1, ST_NOTFOUND, KEY_NONE);
    add_row(OP_INSERT, KEY_MIN,  1, ST_DONE,     KEY_NONE);
    add_row(OP_INSERT, KEY_MAX,  1, ST_DONE,     KEY_NONE);
    add_row(OP_INSERT, KEY_MIN,  1, ST_DUP,      KEY_NONE);
    add_row(OP_INSERT, KEY_NONE, 1, ST_DONE,     KEY_NONE);
    add_row(OP_INSERT, -1,       1, ST_DONE,     KEY_NONE);
    add_row(OP_INSERT, 1,        0, ST_DONE,     KEY_NONE);
    add_row(OP_SEARCH, KEY_MAX,  1, ST_DONE,     KEY_MAX);
    add_row(OP_SEARCH, KEY_MIN,  1, ST_DONE,     KEY_MIN);
    add_row(OP_SEARCH, 2,        1, ST_NOTFOUND, KEY_NONE);
    add_row(OP_SEARCH, -2,       0, ST_DONE,     KEY_NONE);
    add_row(OP_DUMP,   KEY_NONE, 0, ST_DONE,     KEY_NONE);
    add_row(OP_DELETE, KEY_NONE, 0, ST_DONE,     KEY_NONE);
    add_row(OP_DELETE, KEY_MIN,  1, ST_DONE,     KEY_NONE);
    add_row(OP_DELETE, KEY_MIN,  1, ST_NOTFOUND, KEY_NONE);
    add_row(OP_DELETE, KEY_MAX,  1, ST_DONE,     KEY_NONE);
    add_row(OP_DUMP,   -1,       0, ST_DONE,     KEY_NONE);
    add_row(OP_DELETE, -1,       0, ST_DONE,     KEY_NONE);
    add_row(OP_DELETE, 1,        0, ST_DONE,     KEY_NONE);
    add_row(OP_DUMP,   KEY_MIN,  1, ST_EMPTY,    KEY_NONE);
    add_row(OP_SEARCH, KEY_MAX,  1, ST_EMPTY,    KEY_NONE);
    directed_n = directed_plan.size();

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_plan[i])
      offer(directed_plan[i].op, directed_plan[i].key, directed_plan[i].typed,
            directed_plan[i].status, directed_plan[i].key_out);
    drain();

    // Grow until full and beyond, with the long result stall early on.
    random_phase(70, 75, 5, 12, 15, 60, 20, 0);
    drain();
    // Shrink down to empty.
    random_phase(70, 10, 70, 12, 15, 80, -1, 0);
    drain();
    // Mixed traffic, starting with a stretch where neither side stalls.
    random_phase(60, 35, 30, 25, 20, 60, -1, 30);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d operations (%0d directed), %0d results checked, peak fill %0d of %0d.",
             items_sent, directed_n, results_checked, peak_count, CAPACITY);
    $display("Seen: %0d done, %0d duplicate, %0d full, %0d not found, %0d empty, %0d dump keys.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             status_seen[5]);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d failures, %0d results still outstanding", fail_count,
               expected_results.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
